FILE: rtl/mt19937_generator_top_macros.svh
// Assertion helpers for the MT19937 generator. They sample on clk and are
// disabled while rst_n is low.
`ifndef MT19937_GENERATOR_TOP_MACROS_SVH
`define MT19937_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mt19937 generator: property failed");
`define MT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mt19937 generator: forbidden condition");
`else
`define MT_ASSERT(lbl, prop)
`define MT_NEVER(lbl, expr)
`endif
`endif

FILE: rtl/mt_pkg.sv
package mt_pkg;

  localparam int MT_WORD_W        = 32;
  localparam int MT_STATE_WORDS   = 624;
  localparam int MT_MIDDLE_OFFSET = 397;

  localparam logic [MT_WORD_W-1:0] MT_INIT_MULT  = 32'h6c078965;
  localparam logic [MT_WORD_W-1:0] MT_TWIST_XOR  = 32'h9908b0df;
  localparam logic [MT_WORD_W-1:0] MT_UPPER_MASK = 32'h80000000;
  localparam logic [MT_WORD_W-1:0] MT_LOWER_MASK = 32'h7fffffff;
  localparam logic [MT_WORD_W-1:0] MT_TEMPER_B   = 32'h9d2c5680;
  localparam logic [MT_WORD_W-1:0] MT_TEMPER_C   = 32'hefc60000;

  localparam logic MT_OP_SEED = 1'b0;
  localparam logic MT_OP_DRAW = 1'b1;

  function automatic logic [MT_WORD_W-1:0] mt_temper(input logic [MT_WORD_W-1:0] w);
    logic [MT_WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: rtl/mt19937_generator_top.sv
// MT19937 pseudorandom word generator.
// Input channel (in_valid/in_ready, in_op, in_seed_value): op seed fills the
// 624-word state from in_seed_value, twists it once and gives no result;
// op draw returns one tempered word on the output channel
// (out_valid/out_ready, out_random_word).
// in_ready is high only while the sequencer is idle; one item is in work at
// a time. A draw at a position other than 0 reads its word on acceptance,
// then tempers it into the output register; at position 0 the draw first
// twists the table (2 priming reads, 624 twist steps, 1 read). A seed
// writes word 0 on acceptance, then runs 623 fill steps through the init
// multiplier and then the twist.
// The twist runs one word per cycle against a 624 x 32 RAM with two
// registered read ports and one write port.
// Reset clears the position and the output valid flag; the table holds no
// defined contents until the first seed. When the receiver stalls, a finished
// word holds in the output register and the next item is still accepted; a
// second finished word waits in a holding register until the output frees,
// and the input stays blocked meanwhile.
`include "mt19937_generator_top_macros.svh"

module mt19937_generator_top #(
  parameter int STATE_WORDS   = mt_pkg::MT_STATE_WORDS,
  parameter int MIDDLE_OFFSET = mt_pkg::MT_MIDDLE_OFFSET
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [mt_pkg::MT_WORD_W-1:0] in_seed_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mt_pkg::MT_WORD_W-1:0] out_random_word
);

  import mt_pkg::*;

  localparam int AW = $clog2(STATE_WORDS);
  localparam logic [AW:0]   WORDS_EXT = (AW+1)'(STATE_WORDS);
  localparam logic [AW:0]   MID_EXT   = (AW+1)'(MIDDLE_OFFSET);
  localparam logic [AW-1:0] LAST_IDX  = AW'(STATE_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_PRIME0, ST_PRIME1, ST_TWIST, ST_READ, ST_TEMPER, ST_HOLD
  } state_t;

  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    return (s >= WORDS_EXT) ? AW'(s - WORDS_EXT) : AW'(s);
  endfunction

  state_t               state_r, state_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic                 pend_r, pend_nxt;
  logic [MT_WORD_W-1:0] p_r, p_nxt;
  logic [MT_WORD_W-1:0] cur_r, cur_nxt;
  logic [MT_WORD_W-1:0] hold_r, hold_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MT_WORD_W-1:0] out_word_r, out_word_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [MT_WORD_W-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr_a, ram_raddr_b;
  logic [MT_WORD_W-1:0] ram_rdata_a, ram_rdata_b;

  logic                 in_fire;
  logic                 out_free;
  logic [AW-1:0]        pos_adv;
  logic [MT_WORD_W-1:0] mix, prod_lo, fill_word;
  logic [MT_WORD_W-1:0] twist_y, twist_v, tempered;
  logic                 twist_overlap;

  mt_ram #(
    .WIDTH (MT_WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign in_fire         = in_valid & in_ready;
  assign out_free        = ~out_valid_r | out_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign pos_adv         = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;

  // init recurrence: low 32 bits of mult * (p ^ (p >> 30)) plus index
  assign mix       = p_r ^ (p_r >> 30);
  assign prod_lo   = mix * MT_INIT_MULT;
  assign fill_word = prod_lo + MT_WORD_W'(k_r);

  // cur_r holds word k, port a word k+1, port b the middle word
  assign twist_y  = (cur_r & MT_UPPER_MASK) | (ram_rdata_a & MT_LOWER_MASK);
  assign twist_v  = ram_rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? MT_TWIST_XOR : '0);
  assign tempered = mt_temper(ram_rdata_a);

  assign twist_overlap = ram_we && (state_r == ST_TWIST) &&
                         (ram_waddr == ram_raddr_a || ram_waddr == ram_raddr_b);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    p_nxt         = p_r;
    cur_nxt       = cur_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_wdata     = twist_v;
    ram_raddr_a   = pos_r;
    ram_raddr_b   = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == MT_OP_SEED) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_seed_value;
            p_nxt     = in_seed_value;
            k_nxt     = AW'(1);
            pos_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_FILL;
          end else if (pos_r == '0) begin
            pend_nxt  = 1'b1;
            state_nxt = ST_PRIME0;
          end else begin
            state_nxt = ST_TEMPER;
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = fill_word;
        p_nxt     = fill_word;
        if (k_r == LAST_IDX) begin
          state_nxt = ST_PRIME0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_PRIME0: begin
        ram_raddr_a = '0;
        state_nxt   = ST_PRIME1;
      end
      ST_PRIME1: begin
        cur_nxt     = ram_rdata_a;
        ram_raddr_a = AW'(1);
        ram_raddr_b = wrap_idx(MID_EXT);
        k_nxt       = '0;
        state_nxt   = ST_TWIST;
      end
      ST_TWIST: begin
        ram_we      = 1'b1;
        ram_waddr   = k_r;
        ram_wdata   = twist_v;
        cur_nxt     = ram_rdata_a;
        // fetch operands for the next step
        ram_raddr_a = wrap_idx({1'b0, k_r} + (AW+1)'(2));
        ram_raddr_b = wrap_idx({1'b0, k_r} + MID_EXT + (AW+1)'(1));
        if (k_r == LAST_IDX) begin
          state_nxt = pend_r ? ST_READ : ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_READ: begin
        ram_raddr_a = pos_r;
        state_nxt   = ST_TEMPER;
      end
      ST_TEMPER: begin
        pos_nxt  = pos_adv;
        pend_nxt = 1'b0;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = tempered;
          state_nxt     = ST_IDLE;
        end else begin
          hold_nxt  = tempered;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = hold_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    p_r        <= p_nxt;
    cur_r      <= cur_nxt;
    hold_r     <= hold_nxt;
    out_word_r <= out_word_nxt;
  end

  `MT_NEVER(a_pos_range, pos_r > LAST_IDX)
  `MT_NEVER(a_twist_no_overlap, twist_overlap)
  `MT_ASSERT(a_temper_delivers, (state_r == ST_TEMPER && out_free) |=> out_valid_r)
  `MT_ASSERT(a_hold_blocks_input, (state_r == ST_HOLD) |-> !in_ready)

endmodule

FILE: rtl/mt_ram.sv
module mt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
